FILE: rtl/complex_fixed_point_alu_defines.svh
// Assertion macros for the complex fixed-point ALU checker.
// Depends on nothing; included by the checker file only.
`ifndef COMPLEX_FIXED_POINT_ALU_DEFINES_SVH
`define COMPLEX_FIXED_POINT_ALU_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CADU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define CADU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also holds across reset
`define CADU_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/cadu_pkg.sv
// Shared opcodes and control struct for the complex fixed-point ALU.
// No dependencies.
package cadu_pkg;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  typedef struct packed {
    logic is_div;
    logic dz;
    logic neg_re;
    logic neg_im;
    logic big_re;
    logic big_im;
  } ctl_t;

endpackage

FILE: rtl/cadu_if.sv
// Valid/ready channel interfaces for operands and results.
// Depends on nothing.
interface cadu_in_if #(parameter int WORD_BITS = 32);
  logic                        valid;
  logic                        ready;
  logic [1:0]                  req_type;
  logic signed [WORD_BITS-1:0] a_re;
  logic signed [WORD_BITS-1:0] a_im;
  logic signed [WORD_BITS-1:0] b_re;
  logic signed [WORD_BITS-1:0] b_im;
  modport source (output valid, req_type, a_re, a_im, b_re, b_im, input ready);
  modport sink (input valid, req_type, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cadu_out_if #(parameter int WORD_BITS = 32);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] res_re;
  logic signed [WORD_BITS-1:0] res_im;
  logic                        overflow;
  logic                        div_by_zero;
  modport source (output valid, res_re, res_im, overflow, div_by_zero, input ready);
  modport sink (input valid, res_re, res_im, overflow, div_by_zero, output ready);
endinterface

FILE: rtl/cadu_front.sv
// Front end: products, sums, add/sub/mul results and divider set-up.
// Depends on cadu_pkg.
module cadu_front #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    req_type,
  input  logic signed [WORD_BITS-1:0]   a_re,
  input  logic signed [WORD_BITS-1:0]   a_im,
  input  logic signed [WORD_BITS-1:0]   b_re,
  input  logic signed [WORD_BITS-1:0]   b_im,
  output logic                          out_valid,
  input  logic                          out_ready,
  output cadu_pkg::ctl_t                ctl,
  output logic [2*WORD_BITS:0]          side,
  output logic [2*WORD_BITS-1:0]        den,
  output logic [2*WORD_BITS-1:0]        rem_re,
  output logic [2*WORD_BITS-1:0]        rem_im,
  output logic [WORD_BITS-1:0]          nb_re,
  output logic [WORD_BITS-1:0]          nb_im
);
  import cadu_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int PW = 2 * WORD_BITS;
  localparam int NW = 2 * WORD_BITS + FRAC_BITS;

  function automatic logic [W:0] sat(input logic signed [PW:0] x);
    logic signed [PW:0] hi;
    logic signed [PW:0] lo;
    hi = (PW+1)'($signed({1'b0, {(W-1){1'b1}}}));
    lo = -hi - (PW+1)'(1);
    if (x > hi) sat = {1'b1, 1'b0, {(W-1){1'b1}}};
    else if (x < lo) sat = {1'b1, 1'b1, {(W-1){1'b0}}};
    else sat = {1'b0, x[W-1:0]};
  endfunction

  // stage 1: products and add/sub sums
  logic                v1;
  logic                en1;
  logic [1:0]          op1;
  logic signed [PW-1:0] pac, pbd, pad, pbc, pcc, pdd;
  logic signed [W:0]   sre, sim;

  // stage 2: wide sums
  logic                v2;
  logic                en2;
  logic [1:0]          op2;
  logic signed [PW:0]  nre, nim;
  logic [PW-1:0]       den2;
  logic [2*W:0]        side2;

  logic                en3;
  logic                v3;

  assign en3 = !v3 || out_ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ready = en1;
  assign out_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      op1 <= req_type;
      pac <= a_re * b_re;
      pbd <= a_im * b_im;
      pad <= a_re * b_im;
      pbc <= a_im * b_re;
      pcc <= b_re * b_re;
      pdd <= b_im * b_im;
      if (req_type == OP_SUB) begin
        sre <= (W+1)'(a_re) - (W+1)'(b_re);
        sim <= (W+1)'(a_im) - (W+1)'(b_im);
      end else begin
        sre <= (W+1)'(a_re) + (W+1)'(b_re);
        sim <= (W+1)'(a_im) + (W+1)'(b_im);
      end
    end
  end

  logic signed [PW:0] mre, mim;
  logic [W:0]         sat_re, sat_im;

  always_comb begin
    mre = ((PW+1)'(pac) - (PW+1)'(pbd)) >>> FRAC_BITS;
    mim = ((PW+1)'(pad) + (PW+1)'(pbc)) >>> FRAC_BITS;
    if (op1 == OP_MUL) begin
      sat_re = sat(mre);
      sat_im = sat(mim);
    end else begin
      sat_re = sat((PW+1)'(sre));
      sat_im = sat((PW+1)'(sim));
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      op2   <= op1;
      nre   <= (PW+1)'(pac) + (PW+1)'(pbd);
      nim   <= (PW+1)'(pbc) - (PW+1)'(pad);
      den2  <= PW'(pcc) + PW'(pdd);
      side2 <= {sat_re[W-1:0], sat_im[W-1:0], sat_re[W] | sat_im[W]};
    end
  end

  // stage 3: magnitudes, pre-scaled numerators, integer part check
  logic [PW-1:0] mag_re, mag_im;
  logic [NW-1:0] num_re, num_im;
  logic [NW-1:0] top_re, top_im;

  always_comb begin
    mag_re = nre[PW] ? PW'(-nre) : nre[PW-1:0];
    mag_im = nim[PW] ? PW'(-nim) : nim[PW-1:0];
    num_re = NW'(mag_re) << FRAC_BITS;
    num_im = NW'(mag_im) << FRAC_BITS;
    top_re = num_re >> W;
    top_im = num_im >> W;
  end

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      ctl.is_div <= (op2 == OP_DIV);
      ctl.dz     <= (den2 == '0);
      ctl.neg_re <= nre[PW];
      ctl.neg_im <= nim[PW];
      ctl.big_re <= (top_re >= NW'(den2));
      ctl.big_im <= (top_im >= NW'(den2));
      side       <= side2;
      den        <= den2;
      rem_re     <= top_re[PW-1:0];
      rem_im     <= top_im[PW-1:0];
      nb_re      <= num_re[W-1:0];
      nb_im      <= num_im[W-1:0];
    end
  end

endmodule

FILE: rtl/cadu_div_cell.sv
// One restoring-division cell: produces one quotient bit per lane.
// Depends on cadu_pkg.
module cadu_div_cell #(
  parameter int WORD_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  cadu_pkg::ctl_t         ctl_in,
  input  logic [2*WORD_BITS:0]   side_in,
  input  logic [2*WORD_BITS-1:0] den_in,
  input  logic [2*WORD_BITS-1:0] rem_re_in,
  input  logic [2*WORD_BITS-1:0] rem_im_in,
  input  logic [WORD_BITS-1:0]   nb_re_in,
  input  logic [WORD_BITS-1:0]   nb_im_in,
  input  logic [WORD_BITS-1:0]   q_re_in,
  input  logic [WORD_BITS-1:0]   q_im_in,
  output logic                   out_valid,
  input  logic                   out_ready,
  output cadu_pkg::ctl_t         ctl,
  output logic [2*WORD_BITS:0]   side,
  output logic [2*WORD_BITS-1:0] den,
  output logic [2*WORD_BITS-1:0] rem_re,
  output logic [2*WORD_BITS-1:0] rem_im,
  output logic [WORD_BITS-1:0]   nb_re,
  output logic [WORD_BITS-1:0]   nb_im,
  output logic [WORD_BITS-1:0]   q_re,
  output logic [WORD_BITS-1:0]   q_im
);
  import cadu_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int PW = 2 * WORD_BITS;

  logic [PW:0] t_re, t_im, d_re, d_im;

  always_comb begin
    t_re = {rem_re_in, nb_re_in[W-1]};
    t_im = {rem_im_in, nb_im_in[W-1]};
    d_re = t_re - {1'b0, den_in};
    d_im = t_im - {1'b0, den_in};
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (in_ready) out_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ctl    <= ctl_in;
      side   <= side_in;
      den    <= den_in;
      rem_re <= d_re[PW] ? t_re[PW-1:0] : d_re[PW-1:0];
      rem_im <= d_im[PW] ? t_im[PW-1:0] : d_im[PW-1:0];
      nb_re  <= nb_re_in << 1;
      nb_im  <= nb_im_in << 1;
      q_re   <= {q_re_in[W-2:0], ~d_re[PW]};
      q_im   <= {q_im_in[W-2:0], ~d_im[PW]};
    end
  end

endmodule

FILE: rtl/complex_fixed_point_alu.sv
// Complex fixed-point ALU: add, subtract, multiply and divide on Q-format operands.
// Takes in one operation and two complex operands on in_ch, returns one result on out_ch.
// Both channels are valid/ready; a transaction completes when valid and ready are high.
// Pipeline: three front stages (products, wide sums, divider set-up), one division
// cell per result bit (WORD_BITS cells), then an output register that signs and
// saturates the quotient. Throughput is one transaction per cycle while out_ch does
// not stall, set by the cell row which moves each operand one cell per clock.
// Each stage holds its item while the next one is full and stalled, so bubbles are
// squeezed out; when out_ch stalls with every stage full, in_ch.ready drops.
// Reset (synchronous, rst high) empties the pipeline; no result is presented
// until a new transaction enters.
// Results that leave the word range saturate and raise overflow; a divide by zero
// returns zero with div_by_zero set.
module complex_fixed_point_alu #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input logic clk,
  input logic rst,
  cadu_in_if.sink    in_ch,
  cadu_out_if.source out_ch
);
  import cadu_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int PW = 2 * WORD_BITS;

  logic [W:0]     cv;
  logic [W:0]     cr;
  ctl_t           c_ctl  [0:W];
  logic [PW:0]    c_side [0:W];
  logic [PW-1:0]  c_den  [0:W];
  logic [PW-1:0]  c_rre  [0:W];
  logic [PW-1:0]  c_rim  [0:W];
  logic [W-1:0]   c_nre  [0:W];
  logic [W-1:0]   c_nim  [0:W];
  logic [W-1:0]   c_qre  [0:W];
  logic [W-1:0]   c_qim  [0:W];

  cadu_front #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .req_type  (in_ch.req_type),
    .a_re      (in_ch.a_re),
    .a_im      (in_ch.a_im),
    .b_re      (in_ch.b_re),
    .b_im      (in_ch.b_im),
    .out_valid (cv[0]),
    .out_ready (cr[0]),
    .ctl       (c_ctl[0]),
    .side      (c_side[0]),
    .den       (c_den[0]),
    .rem_re    (c_rre[0]),
    .rem_im    (c_rim[0]),
    .nb_re     (c_nre[0]),
    .nb_im     (c_nim[0])
  );

  assign c_qre[0] = '0;
  assign c_qim[0] = '0;

  for (genvar i = 0; i < W; i++) begin : g_cell
    cadu_div_cell #(.WORD_BITS(WORD_BITS)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cv[i]),
      .in_ready  (cr[i]),
      .ctl_in    (c_ctl[i]),
      .side_in   (c_side[i]),
      .den_in    (c_den[i]),
      .rem_re_in (c_rre[i]),
      .rem_im_in (c_rim[i]),
      .nb_re_in  (c_nre[i]),
      .nb_im_in  (c_nim[i]),
      .q_re_in   (c_qre[i]),
      .q_im_in   (c_qim[i]),
      .out_valid (cv[i+1]),
      .out_ready (cr[i+1]),
      .ctl       (c_ctl[i+1]),
      .side      (c_side[i+1]),
      .den       (c_den[i+1]),
      .rem_re    (c_rre[i+1]),
      .rem_im    (c_rim[i+1]),
      .nb_re     (c_nre[i+1]),
      .nb_im     (c_nim[i+1]),
      .q_re      (c_qre[i+1]),
      .q_im      (c_qim[i+1])
    );
  end

  // output stage
  logic         ov;
  logic         o_ready;
  ctl_t         fc;
  logic [W-1:0] qre, qim;
  logic [W:0]   fre, fim;
  logic [W-1:0] res_re_next, res_im_next;
  logic         ovf_next, dz_next;

  assign fc  = c_ctl[W];
  assign qre = c_qre[W];
  assign qim = c_qim[W];

  always_comb begin
    // each lane: {saturated, value}
    if (fc.big_re || (!fc.neg_re && qre[W-1])) fre = {1'b1, 1'b0, {(W-1){1'b1}}};
    else if (fc.neg_re && qre[W-1] && (qre[W-2:0] != '0)) fre = {1'b1, 1'b1, {(W-1){1'b0}}};
    else if (fc.neg_re) fre = {1'b0, -qre};
    else fre = {1'b0, qre};
    if (fc.big_im && fc.neg_im) fim = {1'b1, 1'b1, {(W-1){1'b0}}};
    else if (fc.big_im || (!fc.neg_im && qim[W-1])) fim = {1'b1, 1'b0, {(W-1){1'b1}}};
    else if (fc.neg_im && qim[W-1] && (qim[W-2:0] != '0)) fim = {1'b1, 1'b1, {(W-1){1'b0}}};
    else if (fc.neg_im) fim = {1'b0, -qim};
    else fim = {1'b0, qim};
    if (fc.big_re && fc.neg_re) fre = {1'b1, 1'b1, {(W-1){1'b0}}};
    if (!fc.is_div) begin
      res_re_next = c_side[W][PW:W+1];
      res_im_next = c_side[W][W:1];
      ovf_next    = c_side[W][0];
      dz_next     = 1'b0;
    end else if (fc.dz) begin
      res_re_next = '0;
      res_im_next = '0;
      ovf_next    = 1'b0;
      dz_next     = 1'b1;
    end else begin
      res_re_next = fre[W-1:0];
      res_im_next = fim[W-1:0];
      ovf_next    = fre[W] | fim[W];
      dz_next     = 1'b0;
    end
  end

  assign o_ready      = !ov || out_ch.ready;
  assign cr[W]        = o_ready;
  assign out_ch.valid = ov;

  always_ff @(posedge clk) begin
    if (rst) ov <= 1'b0;
    else if (o_ready) ov <= cv[W];
  end

  always_ff @(posedge clk) begin
    if (o_ready && cv[W]) begin
      out_ch.res_re      <= res_re_next;
      out_ch.res_im      <= res_im_next;
      out_ch.overflow    <= ovf_next;
      out_ch.div_by_zero <= dz_next;
    end
  end

endmodule

FILE: rtl/cadu_checker.sv
// Port-level checks for complex_fixed_point_alu, attached by bind.
// Depends on complex_fixed_point_alu_defines.svh.
`include "complex_fixed_point_alu_defines.svh"

module cadu_checker #(
  parameter int WORD_BITS = 32
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [WORD_BITS-1:0] res_re,
  input logic [WORD_BITS-1:0] res_im,
  input logic                 overflow,
  input logic                 div_by_zero
);
  localparam logic [WORD_BITS-1:0] MAXV = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] MINV = {1'b1, {(WORD_BITS-1){1'b0}}};

  `CADU_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `CADU_ASSERT_ALWAYS(a_rst, rst, !out_valid, "result present after reset")
  `CADU_ASSERT_NOW(a_dz, out_valid && div_by_zero,
    res_re == '0 && res_im == '0 && !overflow, "divide by zero result not clean")
  `CADU_ASSERT_NOW(a_sat, out_valid && overflow,
    res_re == MAXV || res_re == MINV || res_im == MAXV || res_im == MINV,
    "overflow without a saturated part")

endmodule

bind complex_fixed_point_alu cadu_checker #(.WORD_BITS(WORD_BITS)) u_cadu_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .res_re      (out_ch.res_re),
  .res_im      (out_ch.res_im),
  .overflow    (out_ch.overflow),
  .div_by_zero (out_ch.div_by_zero)
);

FILE: bench/tb_complex_fixed_point_alu.sv
// Self-checking bench for the complex fixed-point ALU: directed table, then random traffic.
// Depends on cadu_pkg, the channel interfaces in cadu_if.sv and the ALU top level.
`timescale 1ns / 100ps

module tb_complex_fixed_point_alu;
  import cadu_pkg::*;

  localparam int WB = 32;
  localparam int FB = 16;
  localparam int N_RANDOM = 1880;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = WB + 10;

  typedef logic signed [WB-1:0] word_t;

  typedef struct {
    word_t re;
    word_t im;
    logic  ovf;
    logic  dz;
  } cplx_res_t;

  typedef struct {
    logic [1:0] op;
    word_t      ar, ai, br, bi;
    logic       typed;
    cplx_res_t  res;
  } vec_t;

  localparam word_t W_MAX = 32'sh7fff_ffff;
  localparam word_t W_MIN = 32'sh8000_0000;
  localparam word_t W_ONE = 32'sh0001_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cadu_in_if  #(.WORD_BITS(WB)) in_ch ();
  cadu_out_if #(.WORD_BITS(WB)) out_ch ();

  complex_fixed_point_alu #(.WORD_BITS(WB), .FRAC_BITS(FB)) DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch)
  );

  always #2 clk = ~clk;

  cplx_res_t pending_q[$];
  int n_results = 0;
  int n_mismatch = 0;
  int idle_cycles = 0;

  // clamp a wide value to the word range, flag saturation
  function automatic word_t clamp_word(input logic signed [127:0] v, inout logic ovf);
    if (v > 128'(W_MAX)) begin
      ovf = 1'b1;
      return W_MAX;
    end
    if (v < -(128'sd1 <<< (WB - 1))) begin
      ovf = 1'b1;
      return W_MIN;
    end
    return v[WB-1:0];
  endfunction

  function automatic cplx_res_t alu_result(input logic [1:0] op, input word_t ar, ai, br, bi);
    logic signed [127:0] x1, x2, x3, x4, wre, wim, den;
    cplx_res_t r;
    x1 = ar;
    x2 = ai;
    x3 = br;
    x4 = bi;
    r.ovf = 1'b0;
    r.dz = 1'b0;
    wre = 0;
    wim = 0;
    case (op)
      OP_ADD: begin
        wre = x1 + x3;
        wim = x2 + x4;
      end
      OP_SUB: begin
        wre = x1 - x3;
        wim = x2 - x4;
      end
      OP_MUL: begin
        wre = (x1 * x3 - x2 * x4) >>> FB;
        wim = (x1 * x4 + x2 * x3) >>> FB;
      end
      default: begin
        den = x3 * x3 + x4 * x4;
        if (den == 0) begin
          r.dz = 1'b1;
        end else begin
          // signed division truncates toward zero; den is positive
          wre = ((x1 * x3 + x2 * x4) <<< FB) / den;
          wim = ((x2 * x3 - x1 * x4) <<< FB) / den;
        end
      end
    endcase
    r.re = clamp_word(wre, r.ovf);
    r.im = clamp_word(wim, r.ovf);
    return r;
  endfunction

  function automatic word_t pick_operand();
    case ($urandom_range(0, 5))
      0: return word_t'($urandom_range(0, 1) ? W_MAX : W_MIN);
      1: return word_t'($urandom_range(0, 1) ? 32'sd0 : -32'sd1);
      2: return word_t'($signed($urandom_range(0, 32'h7_ffff)) - 32'sh4_0000);
      3: return word_t'($signed($urandom_range(0, 32'h7ff_ffff)) - 32'sh400_0000);
      default: return word_t'($urandom);
    endcase
  endfunction

  // sender: bursts of random length with random gaps
  int burst_left = 0;

  task automatic send_item(input vec_t v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= v.op;
    in_ch.a_re     <= v.ar;
    in_ch.a_im     <= v.ai;
    in_ch.b_re     <= v.br;
    in_ch.b_im     <= v.bi;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_q.push_back(v.typed ? v.res : alu_result(v.op, v.ar, v.ai, v.br, v.bi));
  endtask

  function automatic vec_t row(input logic [1:0] op, input word_t ar, ai, br, bi);
    vec_t v;
    v.op = op;
    v.ar = ar;
    v.ai = ai;
    v.br = br;
    v.bi = bi;
    v.typed = 1'b0;
    v.res = '{re: '0, im: '0, ovf: 1'b0, dz: 1'b0};
    return v;
  endfunction

  function automatic vec_t row_exp(input logic [1:0] op, input word_t ar, ai, br, bi,
                                   input word_t ere, eim, input logic eovf, edz);
    vec_t v;
    v = row(op, ar, ai, br, bi);
    v.typed = 1'b1;
    v.res = '{re: ere, im: eim, ovf: eovf, dz: edz};
    return v;
  endfunction

  vec_t directed[$];

  initial begin
    vec_t v;
    in_ch.valid    <= 1'b0;
    in_ch.req_type <= OP_ADD;
    in_ch.a_re     <= '0;
    in_ch.a_im     <= '0;
    in_ch.b_re     <= '0;
    in_ch.b_im     <= '0;

    directed = '{
      row_exp(OP_ADD, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0),
      row_exp(OP_ADD, W_MAX, W_MIN, W_MAX, W_MIN, W_MAX, W_MIN, 1'b1, 1'b0),
      row_exp(OP_ADD, W_MAX, 5, 1, -5, W_MAX, 0, 1'b1, 1'b0),
      row_exp(OP_SUB, W_MIN, W_MAX, 1, -1, W_MIN, W_MAX, 1'b1, 1'b0),
      row_exp(OP_SUB, 7, -7, 7, -7, 0, 0, 1'b0, 1'b0),
      row_exp(OP_MUL, W_ONE, 0, W_ONE, 0, W_ONE, 0, 1'b0, 1'b0),
      row_exp(OP_MUL, 0, W_ONE, 0, W_ONE, -W_ONE, 0, 1'b0, 1'b0),
      row_exp(OP_MUL, W_MIN, W_MIN, W_MIN, W_MIN, 0, W_MAX, 1'b1, 1'b0),
      row_exp(OP_DIV, W_MAX, W_MIN, 0, 0, 0, 0, 1'b0, 1'b1),
      row_exp(OP_DIV, 0, 0, 0, 0, 0, 0, 1'b0, 1'b1),
      row_exp(OP_DIV, W_ONE, W_ONE, W_ONE, 0, W_ONE, W_ONE, 1'b0, 1'b0),
      row(OP_MUL, -1, 0, 1, 0),
      row(OP_MUL, W_MAX, W_MAX, W_MAX, W_MIN),
      row(OP_DIV, W_MAX, W_MAX, 1, 0),
      row(OP_DIV, W_MIN, W_MIN, 0, 1),
      row(OP_DIV, -1, 1, W_MIN, W_MIN),
      row(OP_DIV, 3, -3, 7, 1),
      row(OP_DIV, W_ONE, 0, 0, 3 * W_ONE),
      row(OP_DIV, -W_ONE, 0, 3 * W_ONE, 0),
      row(OP_SUB, W_MIN, 0, W_MIN, 0)
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_item(directed[i]);

    for (int k = 0; k < N_RANDOM; k++) begin
      // let the pipeline drain completely once
      if (k == N_RANDOM / 2) begin
        in_ch.valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
      end
      v = row(2'($urandom_range(0, 3)), pick_operand(), pick_operand(),
              pick_operand(), pick_operand());
      send_item(v);
    end
    in_ch.valid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_mismatch == 0 && pending_q.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // receiver: stall pattern whose mode is redrawn at random, plus one long hold
  int rx_cycle = 0;
  int rx_mode = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 64 == 0) rx_mode <= $urandom_range(0, 3);
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!hold_done && n_results >= 500) begin
      hold_done <= 1'b1;
      hold_left <= 300;
      out_ch.ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        2: out_ch.ready <= (rx_cycle % 4 == 0);
        default: out_ch.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin
    cplx_res_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      n_results <= n_results + 1;
      if (pending_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected result: re=%h im=%h ovf=%b dz=%b", out_ch.res_re,
                   out_ch.res_im, out_ch.overflow, out_ch.div_by_zero);
      end else begin
        want = pending_q.pop_front();
        if (out_ch.res_re !== want.re || out_ch.res_im !== want.im ||
            out_ch.overflow !== want.ovf || out_ch.div_by_zero !== want.dz) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: exp re=%h im=%h ovf=%b dz=%b, got re=%h im=%h ovf=%b dz=%b",
                     want.re, want.im, want.ovf, want.dz, out_ch.res_re, out_ch.res_im,
                     out_ch.overflow, out_ch.div_by_zero);
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
